@@ src/steq_pkg.sv @@
// ----------------------------------------------------------------------------
// steq_pkg
// Shared types and constants of the sorted timer event queue.
// ----------------------------------------------------------------------------
package steq_pkg;

  // operation codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_SERVICE = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_STOP    = 2'd3
  } func_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OFF  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // tick interval is the base frequency divided by this
  localparam logic [31:0] DIV_TICK = 32'd20;
  // reciprocal of 5 scaled by 2^34; after a shift by two it divides by 20
  localparam logic [31:0] TICK_RECIP = 32'hCCCC_CCCD;
  // last step of the 64-step restoring divider
  localparam logic [5:0]  DIV_LAST = 6'd63;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        sub;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        carry;
  } alu_rsp_t;

  typedef struct packed {
    logic ins_write;
    logic ins_shift;
    logic pop;
  } queue_cmd_t;

endpackage

@@ src/steq_if.sv @@
// ----------------------------------------------------------------------------
// steq_if
// Valid/ready channels of the timer queue: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface steq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] now;
  logic [31:0] duration;
  logic [15:0] event_tag;

  modport source (output valid, func, now, duration, event_tag, input ready);
  modport sink (input valid, func, now, duration, event_tag, output ready);
endinterface

interface steq_out_if #(
  parameter int QUEUE_DEPTH = 16
);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             valid;
  logic             ready;
  logic             fired;
  logic [15:0]      fired_tag;
  logic [1:0]       status;
  logic [63:0]      next_deadline;
  logic [CNT_W-1:0] pending_count;
  logic             last;

  modport source (output valid, fired, fired_tag, status, next_deadline,
                  pending_count, last, input ready);
  modport sink (input valid, fired, fired_tag, status, next_deadline,
                pending_count, last, output ready);
endinterface

@@ src/steq_alu.sv @@
// ----------------------------------------------------------------------------
// steq_alu
// Shared 64-bit adder/subtractor with carry out; a set carry on a subtract
// means a >= b.
// ----------------------------------------------------------------------------
module steq_alu
  import steq_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [64:0] total;
  logic [63:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff} + {64'b0, req.sub};
  assign rsp.sum   = total[63:0];
  assign rsp.carry = total[64];

endmodule

@@ src/steq_queue.sv @@
// ----------------------------------------------------------------------------
// steq_queue
// Row of event cells sorted by expiry: shift-up insert one cell a cycle,
// shift-down pop of the head, one read port for the sequencer.
// ----------------------------------------------------------------------------
module steq_queue
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16,
  parameter int IDX_W       = 4
) (
  input  logic                clk,
  input  queue_cmd_t          cmd,
  input  logic [IDX_W-1:0]    src_addr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [63:0]         wr_expiry,
  input  logic [TAG_BITS-1:0] wr_tag,
  input  logic [IDX_W-1:0]    rd_addr,
  output logic [63:0]         rd_expiry,
  output logic [TAG_BITS-1:0] head_tag
);

  logic [63:0]         expiry [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] tags   [QUEUE_DEPTH];

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    localparam int Lo = (gi > 0) ? gi - 1 : 0;
    localparam int Hi = (gi < QUEUE_DEPTH - 1) ? gi + 1 : gi;

    always_ff @(posedge clk) begin
      if (cmd.ins_write && wr_addr == IDX_W'(gi)) begin
        expiry[gi] <= wr_expiry;
        tags[gi]   <= wr_tag;
      end else if (cmd.ins_shift && gi > 0 && src_addr == IDX_W'(Lo)) begin
        expiry[gi] <= expiry[Lo];
        tags[gi]   <= tags[Lo];
      end else if (cmd.pop && gi < QUEUE_DEPTH - 1) begin
        expiry[gi] <= expiry[Hi];
        tags[gi]   <= tags[Hi];
      end
    end
  end

  assign rd_expiry = (int'(rd_addr) < QUEUE_DEPTH) ? expiry[rd_addr] : '0;
  assign head_tag  = tags[0];

endmodule

@@ src/sorted_timer_event_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Sorted one-shot timer queue with a periodic tick, run by a small sequencer
// around one shared 64-bit adder/subtractor.
// ----------------------------------------------------------------------------
// One command at a time; in_ch.ready is high only while the block is idle.
// Every arithmetic step (expiry sum, sorted compare, tick catch-up, deadline
// pick) goes through the single 64-bit adder/subtractor, one use per cycle;
// only the tick interval, a fixed division of the base frequency, comes from
// a reciprocal multiply. An add compares the new expiry with each queued
// entry that has a later expiry and with one more unless all of them are
// later. A service first checks the tick when it is armed; when the tick is
// due, the catch-up takes the remainder of a 64-bit by 32-bit division one
// bit a cycle. A service then gives one result beat per expired event, or
// one unfired beat when none has expired.
// Queue storage needs no clearing after reset.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  steq_in_if.sink            in_ch,
  steq_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_INS, S_TCMP, S_DIV, S_TGAP, S_TADD,
    S_TSTART, S_TARM, S_SCAN, S_DL, S_OUT
  } state_t;

  state_t              state;
  logic [31:0]         freq;
  logic [63:0]         now_q;
  logic [31:0]         dur_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [63:0]         exp_q;
  logic [IDX_W-1:0]    ptr;
  logic [CNT_W-1:0]    scan_n;
  logic [CNT_W-1:0]    count;
  logic [31:0]         iv;
  logic [63:0]         td;
  logic [63:0]         dvd;
  logic [31:0]         rem;
  logic [31:0]         dvsr;
  logic [5:0]          step;
  logic [1:0]          status_q;
  logic                out_valid;
  logic                out_fired;
  logic                out_last;
  logic [1:0]          out_status;
  logic [63:0]         out_nd;
  logic [CNT_W-1:0]    out_cnt;
  logic [CNT_W-1:0]    fire_left;

  alu_req_t            alu_req;
  alu_rsp_t            alu_rsp;
  queue_cmd_t          q_cmd;
  logic [IDX_W-1:0]    wr_addr;
  logic [63:0]         wr_exp;
  logic [IDX_W-1:0]    rd_addr;
  logic [63:0]         rd_expiry;
  logic [TAG_BITS-1:0] head_tag;
  logic [63:0]         tick_dl;
  logic [63:0]         tick_prod;
  logic                take_head;
  logic                cfg_we;
  logic [TAG_BITS+15:0] tag_in_wide;
  logic [TAG_BITS+15:0] tag_out_wide;

  steq_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  steq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .IDX_W       (IDX_W)
  ) u_queue (
    .clk       (clk),
    .cmd       (q_cmd),
    .src_addr  (ptr),
    .wr_addr   (wr_addr),
    .wr_expiry (wr_exp),
    .wr_tag    (tag_q),
    .rd_addr   (rd_addr),
    .rd_expiry (rd_expiry),
    .head_tag  (head_tag)
  );

  // config port
  assign cfg_we = psel & penable & pwrite & ~paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : freq;

  assign tag_in_wide  = {{TAG_BITS{1'b0}}, in_ch.event_tag};
  assign tag_out_wide = {16'd0, head_tag};

  // first entry of an empty row is written straight from the sum
  assign wr_exp = (state == S_SUM) ? alu_rsp.sum : exp_q;

  // freq / 20 as (freq >> 2) / 5 by reciprocal multiply
  assign tick_prod = 64'({2'b00, freq[31:2]}) * 64'(TICK_RECIP);

  // a tick deadline of zero counts as no tick
  assign tick_dl   = (iv != 32'd0 && td != 64'd0) ? td : 64'd0;
  assign take_head = (count != '0) && (tick_dl == 64'd0 || !alu_rsp.carry);

  assign rd_addr = (state == S_INS) ? ptr : scan_n[IDX_W-1:0];

  always_comb begin
    alu_req = '0;
    unique case (state)
      S_SUM:  begin alu_req.a = now_q; alu_req.b = {32'd0, dur_q}; end
      S_INS:  begin alu_req.a = exp_q; alu_req.b = rd_expiry; alu_req.sub = 1'b1; end
      S_TCMP: begin alu_req.a = now_q; alu_req.b = td; alu_req.sub = 1'b1; end
      S_DIV: begin
        alu_req.a   = {31'd0, rem, dvd[63]};
        alu_req.b   = {32'd0, dvsr};
        alu_req.sub = 1'b1;
      end
      S_TGAP: begin
        alu_req.a   = {32'd0, dvsr};
        alu_req.b   = {32'd0, rem};
        alu_req.sub = 1'b1;
      end
      S_TADD: begin alu_req.a = now_q; alu_req.b = exp_q; end
      S_TARM: begin alu_req.a = now_q; alu_req.b = {32'd0, iv}; end
      S_SCAN: begin alu_req.a = now_q; alu_req.b = rd_expiry; alu_req.sub = 1'b1; end
      S_DL:   begin alu_req.a = rd_expiry; alu_req.b = tick_dl; alu_req.sub = 1'b1; end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    q_cmd   = '0;
    wr_addr = '0;
    unique case (state)
      S_SUM: q_cmd.ins_write = (count == '0);
      S_INS: begin
        if (alu_rsp.carry) begin
          // new expiry goes behind equal or earlier entries
          q_cmd.ins_write = 1'b1;
          wr_addr         = ptr + IDX_W'(1);
        end else begin
          q_cmd.ins_shift = 1'b1;
          q_cmd.ins_write = (ptr == '0);
        end
      end
      S_OUT: q_cmd.pop = out_ch.ready & out_fired;
      default: q_cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      freq      <= 32'd0;
      count     <= '0;
      iv        <= 32'd0;
      td        <= 64'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        freq <= pwdata;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            now_q    <= in_ch.now;
            dur_q    <= in_ch.duration;
            tag_q    <= tag_in_wide[TAG_BITS-1:0];
            scan_n   <= '0;
            status_q <= STAT_OK;
            unique case (func_t'(in_ch.func))
              FUNC_ADD: begin
                if (freq == 32'd0) begin
                  status_q <= STAT_OFF;
                  state    <= S_DL;
                end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                  status_q <= STAT_FULL;
                  state    <= S_DL;
                end else begin
                  state <= S_SUM;
                end
              end
              FUNC_SERVICE: begin
                if (freq == 32'd0) begin
                  status_q <= STAT_OFF;
                  state    <= S_DL;
                end else if (iv == 32'd0) begin
                  state <= S_SCAN;
                end else begin
                  state <= S_TCMP;
                end
              end
              FUNC_START: begin
                if (freq == 32'd0) begin
                  status_q <= STAT_OFF;
                  state    <= S_DL;
                end else begin
                  state <= S_TSTART;
                end
              end
              FUNC_STOP: begin
                count <= '0;
                iv    <= 32'd0;
                td    <= 64'd0;
                state <= S_DL;
              end
            endcase
          end
        end
        S_SUM: begin
          exp_q <= alu_rsp.sum;
          if (count == '0) begin
            count <= count + CNT_W'(1);
            state <= S_DL;
          end else begin
            ptr   <= IDX_W'(count - CNT_W'(1));
            state <= S_INS;
          end
        end
        S_INS: begin
          if (alu_rsp.carry || ptr == '0) begin
            count <= count + CNT_W'(1);
            state <= S_DL;
          end else begin
            ptr <= ptr - IDX_W'(1);
          end
        end
        S_TCMP: begin
          if (!alu_rsp.carry) begin
            state <= S_SCAN;
          end else begin
            // remainder of (now - deadline) / interval sets the catch-up
            dvd   <= alu_rsp.sum;
            dvsr  <= iv;
            rem   <= 32'd0;
            step  <= 6'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (alu_rsp.carry) begin
            rem <= alu_rsp.sum[31:0];
          end else begin
            rem <= {rem[30:0], dvd[63]};
          end
          dvd  <= {dvd[62:0], alu_rsp.carry};
          step <= step + 6'd1;
          if (step == DIV_LAST) begin
            state <= S_TGAP;
          end
        end
        S_TGAP: begin
          exp_q <= alu_rsp.sum;
          state <= S_TADD;
        end
        S_TADD: begin
          // carry out means the next tick would pass the top of the counter
          td    <= alu_rsp.carry ? '1 : alu_rsp.sum;
          state <= S_SCAN;
        end
        S_TSTART: begin
          iv    <= (tick_prod[63:34] == 30'd0) ? 32'd1 : {2'b00, tick_prod[63:34]};
          state <= S_TARM;
        end
        S_TARM: begin
          td    <= alu_rsp.sum;
          state <= S_DL;
        end
        S_SCAN: begin
          if (scan_n != count && alu_rsp.carry) begin
            scan_n <= scan_n + CNT_W'(1);
          end else begin
            // expired entries stay in the row until their beats pop them
            count <= count - scan_n;
            state <= S_DL;
          end
        end
        S_DL: begin
          out_valid  <= 1'b1;
          out_status <= status_q;
          out_nd     <= take_head ? rd_expiry : tick_dl;
          out_cnt    <= count;
          out_fired  <= (scan_n != '0);
          out_last   <= (scan_n <= CNT_W'(1));
          fire_left  <= scan_n;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (out_fired && fire_left > CNT_W'(1)) begin
              fire_left <= fire_left - CNT_W'(1);
              out_last  <= (fire_left == CNT_W'(2));
            end else begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state == S_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.fired         = out_fired;
  assign out_ch.fired_tag     = out_fired ? tag_out_wide[15:0] : 16'd0;
  assign out_ch.status        = out_status;
  assign out_ch.next_deadline = out_nd;
  assign out_ch.pending_count = out_cnt;
  assign out_ch.last          = out_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("command taken while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.pending_count <= CNT_W'(QUEUE_DEPTH)))
    else $error("pending count above queue depth");

  a_quiet_single: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.fired) |-> out_ch.last)
    else $error("result without fired event is not the last one");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != STAT_OK) |-> !out_ch.fired)
    else $error("event fired on a rejected command");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block not idle after final result beat");
`endif

endmodule
